### rtl/core/one_span_table_decompressor_core_assert.svh
// Assertion macros for the one-span table decompressor core.
`ifndef ONE_SPAN_TABLE_DECOMPRESSOR_CORE_ASSERT_SVH
`define ONE_SPAN_TABLE_DECOMPRESSOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked check, off while reset is held.
`define OSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define OSD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OSD_ASSERT(lbl, prop, msg)
`define OSD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### rtl/core/osd_pkg.sv
// Shared types and constants of the one-span table decompressor.
package osd_pkg;

  localparam int unsigned MAX_ELEMENTS_DEF = 1024;
  localparam int unsigned WORD_W           = 64;
  localparam int unsigned REP_W            = 11;
  localparam int unsigned STATUS_W         = 4;
  localparam int unsigned MEM_ADDR_MAX_W   = 16;

  typedef enum logic [2:0] {
    PH_TSIZE,
    PH_DSIZE,
    PH_TABLE,
    PH_INDEX,
    PH_SPAN,
    PH_DONE
  } phase_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 4'd0,
    ST_NO_HEADER = 4'd1,
    ST_TABLE_BIG = 4'd2,
    ST_DATA_BIG  = 4'd3,
    ST_SHORT     = 4'd4,
    ST_BAD_INDEX = 4'd5,
    ST_SPAN_OUT  = 4'd6,
    ST_SPAN_LONG = 4'd7,
    ST_WRONG_SZ  = 4'd8
  } status_t;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic [REP_W-1:0]  repeat_res;
    logic              has_value;
    logic              done_res;
    status_t           status;
  } res_t;

  typedef struct packed {
    logic                      en;
    logic [MEM_ADDR_MAX_W-1:0] addr;
    logic [WORD_W-1:0]         data;
  } wr_t;

endpackage

### rtl/core/osd_if.sv
// Word and result channel interfaces of the one-span table decompressor.
interface osd_in_if;
  logic                       valid;
  logic                       ready;
  logic [osd_pkg::WORD_W-1:0] word;
  logic                       last;

  modport source (output valid, output word, output last, input ready);
  modport sink (input valid, input word, input last, output ready);
endinterface

interface osd_out_if;
  logic                         valid;
  logic                         ready;
  logic [osd_pkg::WORD_W-1:0]   value;
  logic [osd_pkg::REP_W-1:0]    repeat_res;
  logic                         has_value;
  logic                         done_res;
  logic [osd_pkg::STATUS_W-1:0] status;

  modport source (output valid, output value, output repeat_res, output has_value,
                  output done_res, output status, input ready);
  modport sink (input valid, input value, input repeat_res, input has_value,
                input done_res, input status, output ready);
endinterface

### rtl/core/one_span_table_decompressor_core.sv
// Top level of the one-span table decompressor: input stage, decode and result register.
// Takes one word per cycle while the result side is ready and registers each result.
// When a word is accepted it is registered and the table memory's registered read is
// launched, with the word's low bits as address. When the input stage advances, the
// decode runs against the stream state and its result lands in the result register,
// where it can be taken. A stalled result holds the pipe; with the result side ready
// the block sustains one word every cycle. Table writes and index reads share the
// memory, and an index that hits the entry written in the same cycle is forwarded.
// No clearing pass is needed after reset.
module one_span_table_decompressor_core #(
  parameter int unsigned MAX_ELEMENTS = osd_pkg::MAX_ELEMENTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  osd_in_if.sink    in_ch,
  osd_out_if.source out_ch
);

  localparam int unsigned IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

  logic                       accept;
  logic                       advance;
  logic                       s1_valid_r;
  logic [osd_pkg::WORD_W-1:0] word_r;
  logic                       last_r;
  logic [osd_pkg::WORD_W-1:0] rd_data;
  logic                       out_valid_r;
  osd_pkg::res_t              out_r;
  osd_pkg::res_t              res;
  logic                       res_valid;
  osd_pkg::wr_t               wr;

  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word_r <= in_ch.word;
      last_r <= in_ch.last;
    end
  end

  osd_table_mem #(
    .DEPTH (MAX_ELEMENTS),
    .AW    (IW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (in_ch.word[IW-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr.en),
    .wr_addr (wr.addr[IW-1:0]),
    .wr_data (wr.data)
  );

  osd_decode #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (advance),
    .word      (word_r),
    .last      (last_r),
    .rd_data   (rd_data),
    .res       (res),
    .res_valid (res_valid),
    .wr        (wr)
  );

  // words that produce no result just drain out of the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.value      = out_r.value;
  assign out_ch.repeat_res = out_r.repeat_res;
  assign out_ch.has_value  = out_r.has_value;
  assign out_ch.done_res   = out_r.done_res;
  assign out_ch.status     = out_r.status;

endmodule

### rtl/core/osd_table_mem.sv
// Value table memory: one write port, one registered read port.
module osd_table_mem #(
  parameter int unsigned DEPTH = osd_pkg::MAX_ELEMENTS_DEF,
  parameter int unsigned AW    = 10
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [osd_pkg::WORD_W-1:0] rd_data,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [osd_pkg::WORD_W-1:0] wr_data
);

  logic [osd_pkg::WORD_W-1:0] mem_r [DEPTH];
  logic [osd_pkg::WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // write-first: the last table entry may be indexed by the very next word
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/osd_decode.sv
// Stream state and per-word decode of the one-span table decompressor.
`include "one_span_table_decompressor_core_assert.svh"

module osd_decode #(
  parameter int unsigned MAX_ELEMENTS = osd_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       fire,
  input  logic [osd_pkg::WORD_W-1:0] word,
  input  logic                       last,
  input  logic [osd_pkg::WORD_W-1:0] rd_data,
  output osd_pkg::res_t              res,
  output logic                       res_valid,
  output osd_pkg::wr_t               wr
);

  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);

  osd_pkg::phase_t  phase_r, phase_nxt, phase_step;
  osd_pkg::status_t err_r, err_nxt, err_step, err_fin;
  logic [CW-1:0] table_count_r, table_count_nxt, table_count_step;
  logic [CW-1:0] data_count_r, data_count_nxt, data_count_step;
  logic [CW-1:0] entries_r, entries_nxt, entries_step;
  logic [CW-1:0] produced_r, produced_nxt, produced_step;

  logic          word_big;
  logic          idx_bad;
  logic          is_one;
  logic          span_long;
  logic [CW-1:0] remain;
  logic [CW-1:0] word_cnt;
  logic [CW-1:0] produced_inc;
  logic [CW-1:0] produced_span;
  logic [CW-1:0] entries_inc;
  logic          has;
  logic [osd_pkg::WORD_W-1:0] val;
  logic [osd_pkg::REP_W-1:0]  rep;

  assign word_big      = word > osd_pkg::WORD_W'(MAX_ELEMENTS);
  assign idx_bad       = word >= osd_pkg::WORD_W'(table_count_r);
  assign is_one        = rd_data == osd_pkg::WORD_W'(1);
  assign remain        = data_count_r - produced_r;
  assign span_long     = word > osd_pkg::WORD_W'(remain);
  assign word_cnt      = word[CW-1:0];
  assign produced_inc  = produced_r + CW'(1);
  assign produced_span = produced_r + word_cnt;
  assign entries_inc   = entries_r + CW'(1);

  // next state for one word
  always_comb begin
    phase_step       = phase_r;
    err_step         = err_r;
    table_count_step = table_count_r;
    data_count_step  = data_count_r;
    entries_step     = entries_r;
    produced_step    = produced_r;
    if (err_r == osd_pkg::ST_OK) begin
      unique case (phase_r)
        osd_pkg::PH_TSIZE: begin
          if (last) begin
            err_step = osd_pkg::ST_NO_HEADER;
          end else if (word_big) begin
            err_step = osd_pkg::ST_TABLE_BIG;
          end else begin
            table_count_step = word_cnt;
            phase_step       = osd_pkg::PH_DSIZE;
          end
        end
        osd_pkg::PH_DSIZE: begin
          if (word_big) begin
            err_step = osd_pkg::ST_DATA_BIG;
          end else begin
            data_count_step = word_cnt;
            if (table_count_r != '0) begin
              phase_step = osd_pkg::PH_TABLE;
            end else if (word_cnt != '0) begin
              phase_step = osd_pkg::PH_INDEX;
            end else begin
              phase_step = osd_pkg::PH_DONE;
            end
          end
        end
        osd_pkg::PH_TABLE: begin
          entries_step = entries_inc;
          if (entries_inc >= table_count_r) begin
            phase_step = (data_count_r != '0) ? osd_pkg::PH_INDEX : osd_pkg::PH_DONE;
          end
        end
        osd_pkg::PH_INDEX: begin
          if (idx_bad) begin
            err_step = osd_pkg::ST_BAD_INDEX;
          end else if (is_one) begin
            phase_step = osd_pkg::PH_SPAN;
          end else begin
            produced_step = produced_inc;
            if (produced_inc >= data_count_r) begin
              phase_step = osd_pkg::PH_DONE;
            end
          end
        end
        osd_pkg::PH_SPAN: begin
          if (span_long) begin
            err_step = osd_pkg::ST_SPAN_LONG;
          end else begin
            produced_step = produced_span;
            phase_step    = (produced_span >= data_count_r) ? osd_pkg::PH_DONE
                                                            : osd_pkg::PH_INDEX;
          end
        end
        default: begin
        end
      endcase
    end

    // end-of-stream checks, then a fresh stream
    err_fin = err_step;
    if (last && (err_step == osd_pkg::ST_OK)) begin
      if (phase_step == osd_pkg::PH_TABLE) begin
        err_fin = osd_pkg::ST_SHORT;
      end else if (phase_step == osd_pkg::PH_SPAN) begin
        err_fin = osd_pkg::ST_SPAN_OUT;
      end else if (produced_step != data_count_step) begin
        err_fin = osd_pkg::ST_WRONG_SZ;
      end
    end

    if (last) begin
      phase_nxt       = osd_pkg::PH_TSIZE;
      err_nxt         = osd_pkg::ST_OK;
      table_count_nxt = '0;
      data_count_nxt  = '0;
      entries_nxt     = '0;
      produced_nxt    = '0;
    end else begin
      phase_nxt       = phase_step;
      err_nxt         = err_step;
      table_count_nxt = table_count_step;
      data_count_nxt  = data_count_step;
      entries_nxt     = entries_step;
      produced_nxt    = produced_step;
    end
  end

  // outputs: decoded value and table write
  always_comb begin
    has     = 1'b0;
    val     = '0;
    rep     = '0;
    wr.en   = 1'b0;
    wr.addr = osd_pkg::MEM_ADDR_MAX_W'(entries_r);
    wr.data = word;
    if (err_r == osd_pkg::ST_OK) begin
      unique case (phase_r)
        osd_pkg::PH_TABLE: begin
          wr.en = fire && (entries_r < CW'(MAX_ELEMENTS));
        end
        osd_pkg::PH_INDEX: begin
          if (!idx_bad && !is_one) begin
            has = 1'b1;
            val = rd_data;
            rep = osd_pkg::REP_W'(1);
          end
        end
        osd_pkg::PH_SPAN: begin
          if (!span_long && (word != '0)) begin
            has = 1'b1;
            val = osd_pkg::WORD_W'(1);
            rep = word[osd_pkg::REP_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign res_valid      = last || has;
  assign res.value      = val;
  assign res.repeat_res = rep;
  assign res.has_value  = has;
  assign res.done_res   = last;
  assign res.status     = last ? err_fin : err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= osd_pkg::PH_TSIZE;
      err_r         <= osd_pkg::ST_OK;
      table_count_r <= '0;
      data_count_r  <= '0;
      entries_r     <= '0;
      produced_r    <= '0;
    end else if (fire) begin
      phase_r       <= phase_nxt;
      err_r         <= err_nxt;
      table_count_r <= table_count_nxt;
      data_count_r  <= data_count_nxt;
      entries_r     <= entries_nxt;
      produced_r    <= produced_nxt;
    end
  end

  `OSD_ASSERT(a_prod_le_data, produced_r <= data_count_r, "values produced exceed data size")
  `OSD_ASSERT(a_load_le_table, entries_r <= table_count_r, "entries loaded exceed table size")
  `OSD_ASSERT(a_err_sticky, (err_r != osd_pkg::ST_OK && !(fire && last)) |=> (err_r == $past(err_r)), "error latch changed mid-stream")
  `OSD_ASSERT_ALWAYS(a_last_clears, (rst_n && fire && last) |=> (phase_r == osd_pkg::PH_TSIZE && err_r == osd_pkg::ST_OK), "stream state not cleared after last word")

endmodule
